// File: sv/sli_pkg.sv
// sli_pkg: shared types, request codes and default sizes for the sorted list block
// used by sli_cell, sli_outbuf and sorted_list_insert; no dependencies

package sli_pkg;

    // default sizes
    localparam int DEPTH_DEF   = 16;
    localparam int VALUE_W_DEF = 32;

    // fixed field widths of the request and result ports
    localparam int IN_VALUE_W  = 32;
    localparam int INDEX_W     = 4;
    localparam int OUT_CNT_W   = 5;
    localparam int OUT_VALUE_W = 32;

    // request codes
    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_READ   = 1'b1;

    // link between neighboring cells
    typedef struct packed {
        logic take;   // this cell takes a new entry on an insert
        logic valid;  // this cell holds an entry
    } link_t;

    // one result as it leaves the block
    typedef struct packed {
        logic [OUT_CNT_W-1:0]          position;
        logic [OUT_CNT_W-1:0]          count;
        logic                          full_res;
        logic signed [OUT_VALUE_W-1:0] read_value;
        logic                          read_valid;
    } res_t;

endpackage

// File: sv/sli_cell.sv
// sli_cell: one slot of the sorted list, compares the key and shifts from its left neighbor
// depends on sli_pkg

module sli_cell #(
    parameter int VALUE_WIDTH = sli_pkg::VALUE_W_DEF,
    parameter bit IS_HEAD     = 1'b0
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   ins,
    input  logic [VALUE_WIDTH-1:0] key,
    input  sli_pkg::link_t         left,
    input  logic [VALUE_WIDTH-1:0] left_data,
    output sli_pkg::link_t         right,
    output logic [VALUE_WIDTH-1:0] data
);
    import sli_pkg::*;

    logic [VALUE_WIDTH-1:0] data_reg;
    logic [VALUE_WIDTH-1:0] data_next;
    logic                   valid_reg;
    logic                   valid_next;
    logic                   above;
    logic                   take;

    // head slot moves only for a strictly smaller key, later slots also on equal keys
    always_comb
    begin
        if (IS_HEAD)
            above = $signed(data_reg) > $signed(key);
        else
            above = $signed(data_reg) >= $signed(key);
        take = !valid_reg || above;
    end

    // take the key at the boundary, the left entry above it
    always_comb
    begin
        data_next  = data_reg;
        valid_next = valid_reg;
        if (ins && take)
        begin
            data_next  = left.take ? left_data : key;
            valid_next = valid_reg || left.valid;
        end
    end

    // slot payload, no reset
    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    // slot occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    assign right.take  = take;
    assign right.valid = valid_reg;
    assign data        = data_reg;

endmodule

// File: sv/sli_outbuf.sv
// sli_outbuf: result register with a skid stage so a request is taken while a result waits
// depends on sli_pkg

module sli_outbuf (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  sli_pkg::res_t res,
    output logic          full,
    output logic          out_valid,
    output sli_pkg::res_t out_res,
    input  logic          out_stall
);
    import sli_pkg::*;

    res_t out_reg;
    res_t out_next;
    res_t skid_reg;
    res_t skid_next;
    logic out_valid_reg;
    logic out_valid_next;
    logic skid_valid_reg;
    logic skid_valid_next;
    logic take;

    assign take = out_valid_reg && !out_stall;

    // steer a new result to the output or the skid stage
    always_comb
    begin
        out_next        = out_reg;
        skid_next       = skid_reg;
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        if (skid_valid_reg)
        begin
            if (take)
            begin
                out_next        = skid_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (push)
        begin
            if (!out_valid_reg || take)
            begin
                out_next       = res;
                out_valid_next = 1'b1;
            end
            else
            begin
                skid_next       = res;
                skid_valid_next = 1'b1;
            end
        end
        else if (take)
        begin
            out_valid_next = 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    assign full      = skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_res   = out_reg;

endmodule

// File: sv/sorted_list_insert.sv
// sorted_list_insert: top level, a row of compare-and-shift cells holding an ascending list
// depends on sli_pkg, sli_cell and sli_outbuf

// Keeps an ascending list of up to DEPTH signed values in a row of cells, one slot per
// cell. An insert request compares its value in every cell at once; each occupied cell
// above the value moves one slot up from its left neighbor and the boundary cell takes the
// value, so a value equal to the first entry goes just after it and a value below the
// first entry goes to slot 0. A full list refuses the insert and reports full_res. A read
// request returns the entry at index with read_valid when the index is below the count.
// The compare-and-shift in each cell is combinational, so one request per clock is accepted
// while in_stall is low, and its result is registered in the output buffer, which is two
// deep and lets requests continue to be taken while one result waits; in_stall rises only
// when both of its places are occupied.
// Reads cover the first min(DEPTH,16) slots; position and count report their low 5 bits.

module sorted_list_insert #(
    parameter int DEPTH       = sli_pkg::DEPTH_DEF,
    parameter int VALUE_WIDTH = sli_pkg::VALUE_W_DEF
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    in_valid,
    output logic                                    in_stall,
    input  logic                                    req_type,
    input  logic signed [sli_pkg::IN_VALUE_W-1:0]   value,
    input  logic [sli_pkg::INDEX_W-1:0]             index,
    output logic                                    out_valid,
    input  logic                                    out_stall,
    output logic [sli_pkg::OUT_CNT_W-1:0]           position,
    output logic [sli_pkg::OUT_CNT_W-1:0]           count,
    output logic                                    full_res,
    output logic signed [sli_pkg::OUT_VALUE_W-1:0]  read_value,
    output logic                                    read_valid
);
    import sli_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int RD_N  = (DEPTH < (1 << INDEX_W)) ? DEPTH : (1 << INDEX_W);

    logic                   acc;
    logic                   ins_go;
    logic                   list_full;
    logic [VALUE_WIDTH-1:0] key;
    logic [VALUE_WIDTH-1:0] rd_sel;
    logic                   rd_ok;
    logic [CNT_W-1:0]       slot;
    logic [CNT_W-1:0]       count_reg;
    logic [CNT_W-1:0]       count_next;
    logic                   buf_full;
    res_t                   res;
    res_t                   out_res;

    link_t                  link  [DEPTH+1];
    logic [VALUE_WIDTH-1:0] cdata [DEPTH+1];

    assign acc       = in_valid && !in_stall;
    assign list_full = link[DEPTH].valid;
    assign ins_go    = acc && (req_type == REQ_INSERT) && !list_full;
    assign in_stall  = buf_full;

    // request value brought to the list width
    always_comb
    begin
        logic [VALUE_WIDTH+IN_VALUE_W-1:0] wide;
        wide = {{VALUE_WIDTH{1'b0}}, value};
        key  = wide[VALUE_WIDTH-1:0];
    end

    // row of cells, the head sees an always-occupied neighbor that never shifts
    assign link[0].take  = 1'b0;
    assign link[0].valid = 1'b1;
    assign cdata[0]      = '0;

    for (genvar j = 0; j < DEPTH; j++)
    begin : g_cell
        sli_cell #(
            .VALUE_WIDTH (VALUE_WIDTH),
            .IS_HEAD     (j == 0)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ins       (ins_go),
            .key       (key),
            .left      (link[j]),
            .left_data (cdata[j]),
            .right     (link[j+1]),
            .data      (cdata[j+1])
        );
    end

    // slot of the insert: the first cell that takes
    always_comb
    begin
        slot = '0;
        for (int j = 0; j < DEPTH; j++)
        begin
            if (link[j+1].take && !link[j].take)
                slot = slot | CNT_W'(j);
        end
    end

    // read select over the addressable slots
    always_comb
    begin
        rd_sel = '0;
        for (int i = 0; i < RD_N; i++)
        begin
            if (32'(index) == i)
                rd_sel = cdata[i+1];
        end
        rd_ok = (32'(index) < 32'(count_reg)) && (32'(index) < RD_N);
    end

    // entry count
    always_comb
    begin
        count_next = count_reg;
        if (ins_go)
            count_next = count_reg + CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else
            count_reg <= count_next;
    end

    // assemble the result of this request
    always_comb
    begin
        logic [CNT_W+OUT_CNT_W-1:0]         pos_w;
        logic [CNT_W+OUT_CNT_W-1:0]         cnt_w;
        logic [VALUE_WIDTH+OUT_VALUE_W-1:0] val_w;
        pos_w = {{OUT_CNT_W{1'b0}}, slot};
        cnt_w = {{OUT_CNT_W{1'b0}}, count_next};
        val_w = {{OUT_VALUE_W{1'b0}}, rd_sel};
        res   = '0;
        res.count = cnt_w[OUT_CNT_W-1:0];
        if (req_type == REQ_INSERT)
        begin
            res.full_res = list_full;
            if (!list_full)
                res.position = pos_w[OUT_CNT_W-1:0];
        end
        else if (rd_ok)
        begin
            res.read_value = val_w[OUT_VALUE_W-1:0];
            res.read_valid = 1'b1;
        end
    end

    // result buffer
    sli_outbuf u_outbuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (acc),
        .res       (res),
        .full      (buf_full),
        .out_valid (out_valid),
        .out_res   (out_res),
        .out_stall (out_stall)
    );

    assign position   = out_res.position;
    assign count      = out_res.count;
    assign full_res   = out_res.full_res;
    assign read_value = out_res.read_value;
    assign read_valid = out_res.read_valid;

`ifndef SYNTH
    // count never passes the list size
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(count_reg) <= DEPTH)
        else $error("entry count above list size");

    // last cell occupied exactly when the count says full
    a_full_match: assert property (@(posedge clk) disable iff (!rst_n)
        list_full == (32'(count_reg) == DEPTH))
        else $error("last cell occupancy disagrees with count");

    // an accepted insert into a list with room grows the count by one
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        ins_go |=> count_reg == $past(count_reg) + CNT_W'(1))
        else $error("insert did not grow the count");

    // an occupied tail cell implies an occupied head cell, a check on the contiguous prefix
    a_prefix: assert property (@(posedge clk) disable iff (!rst_n)
        link[DEPTH].valid |-> link[1].valid)
        else $error("tail occupied while head empty");

    // request stall only while a result is waiting
    a_stall_wait: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid)
        else $error("stall with no waiting result");
`endif

endmodule

// File: tb/sv/tb_top.sv
// tb_top: self-checking testbench for sorted_list_insert, with a queue-fed driver and a monitor
// depends on sli_pkg and the sorted_list_insert rtl

module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    import sli_pkg::*;

    localparam int LIST_DEPTH  = DEPTH_DEF;
    localparam int STALL_LIMIT = 1000;

    // one pending request as the driver presents it
    typedef struct {
        logic                         op;
        logic signed [IN_VALUE_W-1:0] value;
        logic [INDEX_W-1:0]           index;
    } list_req_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                          in_valid = 1'b0;
    logic                          in_stall;
    logic                          req_type = REQ_INSERT;
    logic signed [IN_VALUE_W-1:0]  value = '0;
    logic [INDEX_W-1:0]            index = '0;
    logic                          out_valid;
    logic                          out_stall = 1'b0;
    logic [OUT_CNT_W-1:0]          position;
    logic [OUT_CNT_W-1:0]          count;
    logic                          full_res;
    logic signed [OUT_VALUE_W-1:0] read_value;
    logic                          read_valid;

    // shadow copy of the list kept by the predictor
    logic signed [IN_VALUE_W-1:0] list_vals [LIST_DEPTH];
    int                           list_len = 0;

    list_req_t pending_reqs[$];
    res_t      results_due[$];
    list_req_t next_req;

    int reqs_taken = 0;
    int total_reqs = 0;
    int gap_left = 0;
    int stall_left = 0;
    int quiet_cycles = 0;
    int mismatches = 0;
    logic calm;

    sorted_list_insert dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .req_type   (req_type),
        .value      (value),
        .index      (index),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .position   (position),
        .count      (count),
        .full_res   (full_res),
        .read_value (read_value),
        .read_valid (read_valid)
    );

    always #6 clk = ~clk;

    // idling is off in some stretches and over the last part of the run
    assign calm = (reqs_taken >= total_reqs - 200) || (reqs_taken % 300 >= 220);

    // apply one request to the shadow list and return the result it should give
    function automatic res_t apply_list_request(logic op, logic signed [IN_VALUE_W-1:0] v,
                                                logic [INDEX_W-1:0] idx);
        res_t r;
        int   slot;
        bit   found;
        r = '0;
        if (op == REQ_INSERT)
        begin
            if (list_len >= LIST_DEPTH)
            begin
                r.full_res = 1'b1;
            end
            else
            begin
                // below the head or empty list goes to slot 0, else between the first fitting pair, or at the end
                slot = list_len;
                found = 1'b0;
                if (list_len == 0 || v < list_vals[0])
                begin
                    slot = 0;
                    found = 1'b1;
                end
                for (int i = 0; i + 1 < list_len; i++)
                begin
                    if (!found && v >= list_vals[i] && v <= list_vals[i + 1])
                    begin
                        slot = i + 1;
                        found = 1'b1;
                    end
                end
                for (int j = list_len; j > slot; j--)
                begin
                    list_vals[j] = list_vals[j - 1];
                end
                list_vals[slot] = v;
                list_len++;
                r.position = OUT_CNT_W'(slot);
            end
        end
        else if (idx < list_len)
        begin
            r.read_value = list_vals[idx];
            r.read_valid = 1'b1;
        end
        r.count = OUT_CNT_W'(list_len);
        return r;
    endfunction

    // mix of extremes, small values that collide, and full-range values
    function automatic logic signed [IN_VALUE_W-1:0] random_value();
        case ($urandom_range(0, 5))
            0: return 32'sh8000_0000;
            1: return 32'sh7fff_ffff;
            2: return $signed($urandom_range(0, 6)) - 3;
            default: return $urandom;
        endcase
    endfunction

    task automatic add_req(logic op, logic signed [IN_VALUE_W-1:0] v, logic [INDEX_W-1:0] idx);
        list_req_t r;
        r.op = op;
        r.value = v;
        r.index = idx;
        pending_reqs.push_back(r);
    endtask

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want)
        begin
            $error("%s mismatch: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endtask

    // request driver: predicts each accepted request, then presents the next one or idles
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            req_type <= REQ_INSERT;
            value <= '0;
            index <= '0;
            reqs_taken <= 0;
            gap_left = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                results_due.push_back(apply_list_request(req_type, value, index));
                reqs_taken <= reqs_taken + 1;
            end
            if (!in_valid || !in_stall)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (pending_reqs.size() > 0)
                begin
                    next_req = pending_reqs.pop_front();
                    in_valid <= 1'b1;
                    req_type <= next_req.op;
                    value <= next_req.value;
                    index <= next_req.index;
                    if (!calm && $urandom_range(0, 5) == 0)
                        gap_left = $urandom_range(1, 6);
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor: compares each accepted result with the oldest prediction
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (results_due.size() == 0)
                begin
                    $error("result arrived with no request outstanding");
                    mismatches++;
                end
                else
                begin
                    res_t want;
                    want = results_due.pop_front();
                    check_field("position", 32'(want.position), 32'(position));
                    check_field("count", 32'(want.count), 32'(count));
                    check_field("full_res", 32'(want.full_res), 32'(full_res));
                    check_field("read_value", want.read_value, read_value);
                    check_field("read_valid", 32'(want.read_valid), 32'(read_valid));
                end
            end
            if (!calm && stall_left == 0 && $urandom_range(0, 9) == 0)
                stall_left = $urandom_range(1, 6);
            if (stall_left > 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
    end

    // watchdog on cycles with no handshake on either side
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // stimulus and end of run
    initial
    begin
        // reads of the empty list
        add_req(REQ_READ, 32'sh7fff_ffff, 4'd0);
        add_req(REQ_READ, 32'sh8000_0000, 4'd15);
        // first entry, a new minimum, a new maximum
        add_req(REQ_INSERT, 32'sd0, 4'd15);
        add_req(REQ_INSERT, 32'sh8000_0000, 4'd0);
        add_req(REQ_INSERT, 32'sh7fff_ffff, 4'd0);
        // duplicates of an inner entry and of the head, then more inner entries
        add_req(REQ_INSERT, 32'sd0, 4'd0);
        add_req(REQ_INSERT, 32'sh8000_0000, 4'd0);
        add_req(REQ_INSERT, -32'sd1, 4'd0);
        add_req(REQ_INSERT, 32'sh5555_5555, 4'd10);
        add_req(REQ_INSERT, 32'shaaaa_aaaa, 4'd5);
        // reads of head, tail and past the end
        add_req(REQ_READ, 32'sd0, 4'd0);
        add_req(REQ_READ, 32'sd0, 4'd7);
        add_req(REQ_READ, 32'sd0, 4'd8);
        add_req(REQ_READ, 32'sd0, 4'd15);

        // fill the list with random content, then mostly reads and refused inserts
        for (int n = 0; n < 1185; n++)
        begin
            if ($urandom_range(0, 99) < ((n < 40) ? 70 : 25))
                add_req(REQ_INSERT, random_value(), 4'($urandom_range(0, 15)));
            else
                add_req(REQ_READ, $urandom, 4'($urandom_range(0, 15)));
        end
        total_reqs = pending_reqs.size();

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_reqs.size() != 0 || in_valid || results_due.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// File: files.f
sv/sli_pkg.sv
sv/sli_cell.sv
sv/sli_outbuf.sv
sv/sorted_list_insert.sv
tb/sv/tb_top.sv
